FILE: rtl/core/acfb_pkg.sv
// Package for the ASCII command frame builder.
// Holds the request and result transaction types, frame character codes and the hex and decimal helpers.
// No dependencies.
package acfb_pkg;

  localparam logic [7:0] ChStx   = 8'h02;
  localparam logic [7:0] ChEtx   = 8'h03;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChA     = 8'h41;

  localparam logic [13:0] ModeMax = 14'd9999;

  localparam logic [0:0] KindRead  = 1'b0;
  localparam logic [0:0] KindRange = 1'b1;

  typedef struct packed {
    logic [0:0]  kind;
    logic [2:0]  read_count;
    logic [3:0]  read_slot;
    logic [4:0]  channel;
    logic [13:0] range_mode;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {4'b0, nib};
    end else begin
      c = ChA + {4'b0, nib - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [7:0] dec_char(input logic [3:0] d);
    return ChZero + {4'b0, d};
  endfunction

endpackage

FILE: rtl/core/ascii_command_frame_builder_top.sv
// ASCII command frame builder, top level.
// Depends on acfb_pkg for transaction types, character codes and helpers.
//
// Usage:
//   Request channel: a transaction is taken at a clock edge with start_i high
//   and busy_o low. req_i carries kind, count, slot, channel and mode.
//   Result channel: one frame byte per cycle on res_o, marked by valid_o;
//   res_o.last_byte flags the closing LF. The receiver cannot stall.
// The request is registered into the frame state, then the STX byte is
//   registered onto res_o with valid_o high.
// A read frame is 21 bytes, a range-set frame 24 bytes, sent
//   one byte per cycle from the byte position counter. busy_o drops during
//   the last byte, so the next request is taken then and its frame follows
//   with no gap.
// Decimal digits come from a constant-reciprocal digit peeler that runs at
//   byte positions 0 to 5; the checksum accumulates as bytes go out.
// Reset: clears the frame in progress and the strobe; no result is pending.
module ascii_command_frame_builder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  acfb_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             valid_o,
  output acfb_pkg::res_t   res_o
);

  localparam logic [4:0] PosLastRead  = 5'd20;
  localparam logic [4:0] PosLastRange = 5'd23;

  logic           active_q, active_d;
  logic [4:0]     pos_q, pos_d;
  acfb_pkg::req_t req_q;
  logic [7:0]     sum_q, sum_d;
  logic [13:0]    rem_q, rem_d;
  logic [3:0]     d3_q, d3_d, d2_q, d2_d, d1_q, d1_d, d0_q, d0_d;
  logic           valid_q;
  acfb_pkg::res_t res_q, res_d;

  logic           accept;
  logic [4:0]     pos_last;
  logic           at_last;
  logic [7:0]     byte_c;
  logic [7:0]     csum;
  logic [4:0]     pos_etx;
  logic [3:0]     ch_tens;
  logic [3:0]     ch_ones;
  logic [13:0]    mode_sat;
  logic [27:0]    prod_k;
  logic [15:0]    prod_h;
  logic [14:0]    prod_t;

  assign pos_last = (req_q.kind == acfb_pkg::KindRange) ? PosLastRange : PosLastRead;
  assign pos_etx  = pos_last - 5'd4;
  assign at_last  = (pos_q == pos_last);
  assign busy_o   = active_q && !at_last;
  assign accept   = start_i && !busy_o;
  assign csum     = 8'(~sum_q + 8'd1);

  assign mode_sat = (req_i.range_mode > acfb_pkg::ModeMax) ? acfb_pkg::ModeMax
                                                          : req_i.range_mode;

  always_comb begin
    if (req_q.channel >= 5'd30) begin
      ch_tens = 4'd3;
      ch_ones = 4'(req_q.channel - 5'd30);
    end else if (req_q.channel >= 5'd20) begin
      ch_tens = 4'd2;
      ch_ones = 4'(req_q.channel - 5'd20);
    end else if (req_q.channel >= 5'd10) begin
      ch_tens = 4'd1;
      ch_ones = 4'(req_q.channel - 5'd10);
    end else begin
      ch_tens = 4'd0;
      ch_ones = req_q.channel[3:0];
    end
  end

  // byte at the current frame position
  always_comb begin
    byte_c = acfb_pkg::ChZero;
    if (pos_q == pos_etx) begin
      byte_c = acfb_pkg::ChEtx;
    end else if (pos_q == pos_etx + 5'd1) begin
      byte_c = acfb_pkg::hex_char(csum[7:4]);
    end else if (pos_q == pos_etx + 5'd2) begin
      byte_c = acfb_pkg::hex_char(csum[3:0]);
    end else if (pos_q == pos_etx + 5'd3) begin
      byte_c = acfb_pkg::ChCr;
    end else if (pos_q == pos_last) begin
      byte_c = acfb_pkg::ChLf;
    end else begin
      case (pos_q)
        5'd0:  byte_c = acfb_pkg::ChStx;
        5'd1:  byte_c = acfb_pkg::ChZero;
        5'd2:  byte_c = acfb_pkg::ChOne;
        5'd3:  byte_c = acfb_pkg::ChZero;
        5'd4:  byte_c = acfb_pkg::ChOne;
        5'd5:  byte_c = acfb_pkg::ChX;
        5'd6:  byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::ChW : acfb_pkg::ChR;
        5'd7:  byte_c = acfb_pkg::ChS;
        5'd8:  byte_c = acfb_pkg::ChComma;
        5'd9:  byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::ChThree
                                                            : acfb_pkg::ChOne;
        5'd10: byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::ChZero
                                                            : acfb_pkg::dec_char(d2_q);
        5'd11: byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::dec_char(ch_tens)
                                                            : acfb_pkg::dec_char(d1_q);
        5'd12: byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::dec_char(ch_ones)
                                                            : acfb_pkg::dec_char(d0_q);
        5'd13: byte_c = acfb_pkg::ChW;
        5'd14: byte_c = acfb_pkg::ChComma;
        5'd15: byte_c = (req_q.kind == acfb_pkg::KindRange) ? acfb_pkg::dec_char(d3_q)
                                                            : acfb_pkg::ChZero
                                                              | {5'b0, req_q.read_count};
        5'd16: byte_c = acfb_pkg::dec_char(d2_q);
        5'd17: byte_c = acfb_pkg::dec_char(d1_q);
        5'd18: byte_c = acfb_pkg::dec_char(d0_q);
        default: byte_c = acfb_pkg::ChZero;
      endcase
    end
  end

  // digit peeler: v/1000 ~ v*8389>>23, r/100 ~ r*41>>12, r/10 ~ r*205>>11
  assign prod_k = {14'b0, rem_q} * 28'd8389;
  assign prod_h = {6'b0, rem_q[9:0]} * 16'd41;
  assign prod_t = {8'b0, rem_q[6:0]} * 15'd205;

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    rem_d    = rem_q;
    d3_d     = d3_q;
    d2_d     = d2_q;
    d1_d     = d1_q;
    d0_d     = d0_q;
    res_d.frame_byte = byte_c;
    res_d.last_byte  = active_q && at_last;
    if (active_q) begin
      pos_d = pos_q + 5'd1;
      if (pos_q <= pos_etx) begin
        sum_d = sum_q + byte_c;
      end
      case (pos_q)
        5'd0: d3_d = prod_k[26:23];
        5'd1: rem_d = rem_q - 14'(d3_q) * 14'd1000;
        5'd2: d2_d = prod_h[15:12];
        5'd3: rem_d = rem_q - 14'(d2_q) * 14'd100;
        5'd4: d1_d = prod_t[14:11];
        5'd5: d0_d = 4'(rem_q - 14'(d1_q) * 14'd10);
        default: ;
      endcase
      if (at_last) begin
        active_d = 1'b0;
      end
    end
    if (accept) begin
      active_d = 1'b1;
      pos_d    = 5'd0;
      sum_d    = 8'd0;
      rem_d    = (req_i.kind == acfb_pkg::KindRange) ? mode_sat
                                                     : {11'b0, req_i.read_count}
                                                       * {10'b0, req_i.read_slot};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= 5'd0;
      valid_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      valid_q  <= active_q;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    sum_q <= sum_d;
    rem_q <= rem_d;
    d3_q  <= d3_d;
    d2_q  <= d2_d;
    d1_q  <= d1_d;
    d0_q  <= d0_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> active_q)
    else $error("busy without a frame in progress");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.last_byte |-> valid_o)
    else $error("last byte flagged without strobe");

  a_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 (valid_o && res_o.frame_byte == acfb_pkg::ChStx))
    else $error("frame does not open with STX");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q <= pos_last))
    else $error("byte position past frame end");
`endif

endmodule
